@@ hw/rtl/rtdt_pkg.sv @@
`timescale 1ns / 1ps

package rtdt_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int COORD_W    = $clog2(MAX_DIM + 1);
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  // Raw box bounds reach 2048 from a 16-bit position; frame clamp to 512
  localparam int BOX_W      = 13;

  localparam int CFG_W      = 10;
  localparam int POS_W      = 16;
  localparam int ATTR_W     = 24;
  localparam int COLOR_W    = 8;
  localparam int AREA_W     = 34;
  localparam int ACC_W      = 58;
  localparam int CNT_W      = $clog2(ATTR_W);

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

  localparam logic [1:0] SLOT_SETUP = 2'd2;
  localparam logic [1:0] SLOT_NONE  = 2'd3;

  // One queued step: either "no scan" or a box pixel
  typedef struct packed {
    logic               no_scan;
    logic               last;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } item_t;

  // Triangle as seen by the back end
  typedef struct packed {
    logic [2:0][POS_W-1:0]   vx;
    logic [2:0][POS_W-1:0]   vy;
    logic [2:0][ATTR_W-1:0]  vz;
    logic [2:0][ATTR_W-1:0]  vw;
    logic [2:0][COLOR_W-1:0] cr;
    logic [2:0][COLOR_W-1:0] cg;
    logic [2:0][COLOR_W-1:0] cb;
    logic [AREA_W-1:0]       area;
  } tri_t;

  typedef struct packed {
    logic idle;
    logic clearing;
  } back_status_t;

endpackage

@@ hw/rtl/triangle_rasterizer_depth_test_unit.sv @@
`timescale 1ns / 1ps

// Edge-function triangle rasterizer with an inverse-depth buffer. Issue an item
// by raising start while busy is low; a load item stores one vertex for slot
// 0 to 2 (slot 2 also sets up the bounding box and area), a step item visits
// the next box pixel. Every step gives exactly one result, shown for one cycle
// with result_strobe high; the receiver cannot stall it, so it must take each
// transfer as it comes. Steps are taken ahead of the back end while the
// two-entry step queue has room. The back end answers a no-scan step from the
// queue, an outside pixel after the edge test, a pixel that fails the depth
// test after the inverse depth and a visible fragment after depth and colors;
// these come from the shared bit-serial multiply-accumulate and divide unit, 24
// steps each for the two depths and 8 each for the colors. A load waits until
// all queued steps are finished; loading slot 2 then passes through the box and
// area setup states. After reset, busy stays high while the depth store is
// cleared. Frame size registers sit at byte addresses 0 (width) and 4 (height).

module triangle_rasterizer_depth_test_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [1:0]         vertex_slot,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [23:0]        depth_z,
  input  logic [23:0]        inv_w,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic               result_strobe,
  output logic               frag_valid,
  output logic [8:0]         frag_x,
  output logic [8:0]         frag_y,
  output logic [23:0]        frag_z,
  output logic [23:0]        frag_inv_depth,
  output logic [7:0]         frag_red,
  output logic [7:0]         frag_green,
  output logic [7:0]         frag_blue,
  output logic               scan_done,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rtdt_pkg::*;

  item_t        push_item, pop_item;
  logic         push, pop;
  logic         fifo_full, fifo_empty;
  back_status_t bstat;
  tri_t         tri_data;

  assign pready = 1'b1;

  // Front: accepts items, walks the box, owns triangle setup and config
  rtdt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .vertex_slot(vertex_slot),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .depth_z    (depth_z),
    .inv_w      (inv_w),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .push       (push),
    .push_item  (push_item),
    .fifo_full  (fifo_full),
    .fifo_empty (fifo_empty),
    .bstat      (bstat),
    .tri_data   (tri_data)
  );

  // Short step queue decouples the scan walk from fragment work
  rtdt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .pop_item (pop_item),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  // Back: edge tests, interpolation, depth store, result register
  rtdt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_item      (pop_item),
    .fifo_empty    (fifo_empty),
    .pop           (pop),
    .tri_data      (tri_data),
    .status        (bstat),
    .result_strobe (result_strobe),
    .frag_valid    (frag_valid),
    .frag_x        (frag_x),
    .frag_y        (frag_y),
    .frag_z        (frag_z),
    .frag_inv_depth(frag_inv_depth),
    .frag_red      (frag_red),
    .frag_green    (frag_green),
    .frag_blue     (frag_blue),
    .scan_done     (scan_done)
  );

endmodule

@@ hw/rtl/rtdt_fifo.sv @@
`timescale 1ns / 1ps

module rtdt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rtdt_pkg::item_t push_item,
  input  logic           pop,
  output rtdt_pkg::item_t pop_item,
  output logic           full,
  output logic           empty
);
  import rtdt_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/rtdt_front.sv @@
`timescale 1ns / 1ps

module rtdt_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 kind,
  input  logic [1:0]           vertex_slot,
  input  logic signed [15:0]   pos_x,
  input  logic signed [15:0]   pos_y,
  input  logic [23:0]          depth_z,
  input  logic [23:0]          inv_w,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 push,
  output rtdt_pkg::item_t      push_item,
  input  logic                 fifo_full,
  input  logic                 fifo_empty,
  input  rtdt_pkg::back_status_t bstat,
  output rtdt_pkg::tri_t       tri_data
);
  import rtdt_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_WAIT, F_BOX, F_AREA} fstate_t;

  fstate_t state;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  logic [1:0]         pend_slot;
  logic [POS_W-1:0]   pend_x, pend_y;
  logic [ATTR_W-1:0]  pend_z, pend_w;
  logic [COLOR_W-1:0] pend_r, pend_g, pend_b;

  logic [BOX_W-1:0]   box_xs, box_xe, box_ys, box_ye;
  logic [COORD_W-1:0] scan_column, scan_row;
  logic               scan_active;
  logic signed [33:0] prod_a, prod_b;

  logic               accept;
  logic               step_last;
  logic               row_wrap;
  logic signed [15:0] minx, maxx, miny, maxy;
  logic [BOX_W-1:0]   xs_raw, xe_raw, ys_raw, ye_raw, fw, fh;
  logic signed [16:0] dx1, dy1, dx2, dy2;
  logic signed [34:0] area;
  logic [16:0]        maxx_up, maxy_up;

  assign accept = start && !busy;
  assign busy   = (state != F_IDLE) || fifo_full || bstat.clearing;

  // Config port
  assign prdata = {{(32 - CFG_W){1'b0}},
                   (reg_idx_t'(paddr[2]) == REG_FRAME_HEIGHT) ? frame_height : frame_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(512);
      frame_height <= CFG_W'(512);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  // Scan walk: y inner, x outer
  assign row_wrap  = (BOX_W'(scan_row) + BOX_W'(1)) >= box_ye;
  assign step_last = ((BOX_W'(scan_column) + BOX_W'(1)) >= box_xe) && row_wrap;
  assign push      = accept && (kind_t'(kind) == KIND_STEP);

  always_comb begin
    push_item.no_scan = !scan_active;
    push_item.last    = step_last;
    push_item.x       = scan_column;
    push_item.y       = scan_row;
  end

  // Setup arithmetic
  always_comb begin
    minx = $signed(tri_data.vx[0]);
    maxx = $signed(tri_data.vx[0]);
    miny = $signed(tri_data.vy[0]);
    maxy = $signed(tri_data.vy[0]);
    for (int i = 1; i < 3; i++) begin
      if ($signed(tri_data.vx[i]) < minx) minx = $signed(tri_data.vx[i]);
      if ($signed(tri_data.vx[i]) > maxx) maxx = $signed(tri_data.vx[i]);
      if ($signed(tri_data.vy[i]) < miny) miny = $signed(tri_data.vy[i]);
      if ($signed(tri_data.vy[i]) > maxy) maxy = $signed(tri_data.vy[i]);
    end
    maxx_up = {1'b0, maxx} + 17'd15;
    maxy_up = {1'b0, maxy} + 17'd15;
    xs_raw  = minx[15] ? '0 : BOX_W'(minx[15:4]);
    ys_raw  = miny[15] ? '0 : BOX_W'(miny[15:4]);
    xe_raw  = (maxx > 16'sd0) ? BOX_W'(maxx_up[16:4]) : '0;
    ye_raw  = (maxy > 16'sd0) ? BOX_W'(maxy_up[16:4]) : '0;
    fw = (BOX_W'(frame_width)  > BOX_W'(MAX_WIDTH))  ? BOX_W'(MAX_WIDTH)  : BOX_W'(frame_width);
    fh = (BOX_W'(frame_height) > BOX_W'(MAX_HEIGHT)) ? BOX_W'(MAX_HEIGHT) : BOX_W'(frame_height);
    dx1 = {tri_data.vx[1][15], tri_data.vx[1]} - {tri_data.vx[0][15], tri_data.vx[0]};
    dy1 = {tri_data.vy[1][15], tri_data.vy[1]} - {tri_data.vy[0][15], tri_data.vy[0]};
    dx2 = {tri_data.vx[2][15], tri_data.vx[2]} - {tri_data.vx[0][15], tri_data.vx[0]};
    dy2 = {tri_data.vy[2][15], tri_data.vy[2]} - {tri_data.vy[0][15], tri_data.vy[0]};
    area = {prod_a[33], prod_a} - {prod_b[33], prod_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      scan_active <= 1'b0;
      scan_column <= '0;
      scan_row    <= '0;
      box_xs      <= '0;
      box_xe      <= '0;
      box_ys      <= '0;
      box_ye      <= '0;
      tri_data    <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (kind_t'(kind) == KIND_STEP) begin
              if (scan_active) begin
                if (row_wrap) begin
                  scan_row    <= box_ys[COORD_W-1:0];
                  scan_column <= scan_column + COORD_W'(1);
                end else begin
                  scan_row <= scan_row + COORD_W'(1);
                end
                if (step_last) scan_active <= 1'b0;
              end
            end else if (vertex_slot != SLOT_NONE) begin
              pend_slot <= vertex_slot;
              pend_x    <= pos_x;
              pend_y    <= pos_y;
              pend_z    <= depth_z;
              pend_w    <= inv_w;
              pend_r    <= red;
              pend_g    <= green;
              pend_b    <= blue;
              state     <= F_WAIT;
            end
          end
        end
        F_WAIT: begin
          // hold the vertex until the back end is done with the old triangle
          if (fifo_empty && bstat.idle) begin
            tri_data.vx[pend_slot] <= pend_x;
            tri_data.vy[pend_slot] <= pend_y;
            tri_data.vz[pend_slot] <= pend_z;
            tri_data.vw[pend_slot] <= pend_w;
            tri_data.cr[pend_slot] <= pend_r;
            tri_data.cg[pend_slot] <= pend_g;
            tri_data.cb[pend_slot] <= pend_b;
            scan_active <= 1'b0;
            state <= (pend_slot == SLOT_SETUP) ? F_BOX : F_IDLE;
          end
        end
        F_BOX: begin
          box_xs <= xs_raw;
          box_ys <= ys_raw;
          box_xe <= (xe_raw > fw) ? fw : xe_raw;
          box_ye <= (ye_raw > fh) ? fh : ye_raw;
          prod_a <= dx1 * dy2;
          prod_b <= dy1 * dx2;
          state  <= F_AREA;
        end
        F_AREA: begin
          tri_data.area <= area[AREA_W-1:0];
          if (!area[34] && (area != '0) && (box_xe > box_xs) && (box_ye > box_ys)) begin
            scan_active <= 1'b1;
            scan_column <= box_xs[COORD_W-1:0];
            scan_row    <= box_ys[COORD_W-1:0];
          end else begin
            scan_active <= 1'b0;
          end
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/rtdt_back.sv @@
`timescale 1ns / 1ps

module rtdt_back (
  input  logic                   clk,
  input  logic                   rst,
  input  rtdt_pkg::item_t        pop_item,
  input  logic                   fifo_empty,
  output logic                   pop,
  input  rtdt_pkg::tri_t         tri_data,
  output rtdt_pkg::back_status_t status,
  output logic                   result_strobe,
  output logic                   frag_valid,
  output logic [8:0]             frag_x,
  output logic [8:0]             frag_y,
  output logic [23:0]            frag_z,
  output logic [23:0]            frag_inv_depth,
  output logic [7:0]             frag_red,
  output logic [7:0]             frag_green,
  output logic [7:0]             frag_blue,
  output logic                   scan_done
);
  import rtdt_pkg::*;

  localparam int DIFF_W = 19;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int EDGE_W = PROD_W + 1;

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_MUL, B_EDGE, B_MAC, B_DIV, B_TEST} bstate_t;
  typedef enum logic [2:0] {A_INVW, A_Z, A_R, A_G, A_B} attr_t;

  bstate_t state;
  attr_t   attr;
  item_t   item;

  logic [ATTR_W-1:0] mem [DEPTH];
  logic [ATTR_W-1:0] rd_data;
  logic [ADDR_W-1:0] clear_addr;
  logic [ADDR_W-1:0] pix_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ATTR_W-1:0] mem_wdata;

  logic signed [PROD_W-1:0] prod_a [3];
  logic signed [PROD_W-1:0] prod_b [3];
  logic signed [DIFF_W-1:0] ea [3], eb [3], pa [3], pb [3];
  logic signed [EDGE_W-1:0] edge_fn [3];
  logic signed [DIFF_W-1:0] vxe [3], vye [3];
  logic signed [DIFF_W-1:0] px, py;

  logic [AREA_W-1:0] w [3];
  logic [ACC_W-1:0]  acc, den, mac_sum;
  logic [ATTR_W-1:0] quo, q_next;
  logic [CNT_W-1:0]  cnt;
  logic [ATTR_W-1:0] aval [3];
  logic              ge;

  logic [ATTR_W-1:0]  invd, zval;
  logic [COLOR_W-1:0] rval, gval;

  assign status.idle     = (state == B_IDLE);
  assign status.clearing = (state == B_CLEAR);
  assign pop             = (state == B_IDLE) && !fifo_empty;
  assign pix_addr        = ADDR_W'(ADDR_W'(item.y) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(item.x);

  // Edge setup: weight for edge k is (q - p) x (P - p)
  always_comb begin
    px = $signed({{(DIFF_W - COORD_W - 4){1'b0}}, item.x, 4'b0000});
    py = $signed({{(DIFF_W - COORD_W - 4){1'b0}}, item.y, 4'b0000});
    for (int i = 0; i < 3; i++) begin
      vxe[i] = DIFF_W'($signed(tri_data.vx[i]));
      vye[i] = DIFF_W'($signed(tri_data.vy[i]));
    end
    // ab: v0 -> v1, ca: v2 -> v0, bc: v1 -> v2
    ea[0] = vxe[1] - vxe[0]; pa[0] = py - vye[0];
    eb[0] = vye[1] - vye[0]; pb[0] = px - vxe[0];
    ea[1] = vxe[0] - vxe[2]; pa[1] = py - vye[2];
    eb[1] = vye[0] - vye[2]; pb[1] = px - vxe[2];
    ea[2] = vxe[2] - vxe[1]; pa[2] = py - vye[1];
    eb[2] = vye[2] - vye[1]; pb[2] = px - vxe[1];
    for (int i = 0; i < 3; i++) begin
      edge_fn[i] = {prod_a[i][PROD_W-1], prod_a[i]} - {prod_b[i][PROD_W-1], prod_b[i]};
    end
  end

  // Attribute operands per vertex
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (attr)
        A_INVW:  aval[i] = tri_data.vw[i];
        A_Z:     aval[i] = tri_data.vz[i];
        A_R:     aval[i] = ATTR_W'(tri_data.cr[i]);
        A_G:     aval[i] = ATTR_W'(tri_data.cg[i]);
        A_B:     aval[i] = ATTR_W'(tri_data.cb[i]);
        default: aval[i] = '0;
      endcase
    end
    // w0 pairs with v0 (edge bc), w1 with v1 (ca), w2 with v2 (ab)
    mac_sum = (aval[0][cnt] ? ACC_W'(w[0]) : '0) +
              (aval[1][cnt] ? ACC_W'(w[1]) : '0) +
              (aval[2][cnt] ? ACC_W'(w[2]) : '0);
    ge     = acc >= den;
    q_next = {quo[ATTR_W-2:0], ge};
  end

  // Depth store
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pix_addr;
    mem_wdata = invd;
    if (state == B_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else if ((state == B_TEST) && (invd > rd_data)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[pix_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_CLEAR;
      clear_addr    <= '0;
      result_strobe <= 1'b0;
      attr          <= A_INVW;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        B_CLEAR: begin
          clear_addr <= clear_addr + ADDR_W'(1);
          if (clear_addr == ADDR_W'(DEPTH - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (!fifo_empty) begin
            item <= pop_item;
            if (pop_item.no_scan) begin
              result_strobe  <= 1'b1;
              frag_valid     <= 1'b0;
              frag_x         <= '0;
              frag_y         <= '0;
              frag_z         <= '0;
              frag_inv_depth <= '0;
              frag_red       <= '0;
              frag_green     <= '0;
              frag_blue      <= '0;
              scan_done      <= 1'b1;
            end else begin
              state <= B_MUL;
            end
          end
        end
        B_MUL: begin
          for (int i = 0; i < 3; i++) begin
            prod_a[i] <= ea[i] * pa[i];
            prod_b[i] <= eb[i] * pb[i];
          end
          state <= B_EDGE;
        end
        B_EDGE: begin
          if (edge_fn[0][EDGE_W-1] || edge_fn[1][EDGE_W-1] || edge_fn[2][EDGE_W-1]) begin
            result_strobe  <= 1'b1;
            frag_valid     <= 1'b0;
            frag_x         <= '0;
            frag_y         <= '0;
            frag_z         <= '0;
            frag_inv_depth <= '0;
            frag_red       <= '0;
            frag_green     <= '0;
            frag_blue      <= '0;
            scan_done      <= item.last;
            state          <= B_IDLE;
          end else begin
            // weights sum to the area, so each fits the area width
            w[0]  <= edge_fn[2][AREA_W-1:0];
            w[1]  <= edge_fn[1][AREA_W-1:0];
            w[2]  <= edge_fn[0][AREA_W-1:0];
            attr  <= A_INVW;
            cnt   <= CNT_W'(ATTR_W - 1);
            acc   <= '0;
            state <= B_MAC;
          end
        end
        B_MAC: begin
          acc <= {acc[ACC_W-2:0], 1'b0} + mac_sum;
          if (cnt == '0) begin
            quo   <= '0;
            state <= B_DIV;
            if ((attr == A_INVW) || (attr == A_Z)) begin
              den <= ACC_W'(tri_data.area) << (ATTR_W - 1);
              cnt <= CNT_W'(ATTR_W - 1);
            end else begin
              den <= ACC_W'(tri_data.area) << (COLOR_W - 1);
              cnt <= CNT_W'(COLOR_W - 1);
            end
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        B_DIV: begin
          den <= den >> 1;
          quo <= q_next;
          if (cnt != '0) begin
            if (ge) acc <= acc - den;
            cnt <= cnt - CNT_W'(1);
          end else begin
            // last quotient bit; remainder no longer needed
            acc <= '0;
            cnt <= CNT_W'(COLOR_W - 1);
            unique case (attr)
              A_INVW: begin
                invd  <= q_next;
                state <= B_TEST;
              end
              A_Z: begin
                zval  <= q_next;
                attr  <= A_R;
                state <= B_MAC;
              end
              A_R: begin
                rval  <= q_next[COLOR_W-1:0];
                attr  <= A_G;
                state <= B_MAC;
              end
              A_G: begin
                gval  <= q_next[COLOR_W-1:0];
                attr  <= A_B;
                state <= B_MAC;
              end
              default: begin
                result_strobe  <= 1'b1;
                frag_valid     <= 1'b1;
                frag_x         <= item.x[8:0];
                frag_y         <= item.y[8:0];
                frag_z         <= zval;
                frag_inv_depth <= invd;
                frag_red       <= rval;
                frag_green     <= gval;
                frag_blue      <= q_next[COLOR_W-1:0];
                scan_done      <= item.last;
                state          <= B_IDLE;
              end
            endcase
          end
        end
        B_TEST: begin
          if (invd > rd_data) begin
            attr  <= A_Z;
            cnt   <= CNT_W'(ATTR_W - 1);
            acc   <= '0;
            state <= B_MAC;
          end else begin
            result_strobe  <= 1'b1;
            frag_valid     <= 1'b0;
            frag_x         <= '0;
            frag_y         <= '0;
            frag_z         <= '0;
            frag_inv_depth <= '0;
            frag_red       <= '0;
            frag_green     <= '0;
            frag_blue      <= '0;
            scan_done      <= item.last;
            state          <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
